/* sv/umpsx_pkg.sv */
`default_nettype none
package umpsx_pkg;

   localparam logic [7:0] SX_START_BYTE = 8'hF0;
   localparam logic [7:0] SX_END_BYTE   = 8'hF7;

   localparam logic [3:0] SX_STAT_COMPLETE = 4'h0;
   localparam logic [3:0] SX_STAT_START    = 4'h1;
   localparam logic [3:0] SX_STAT_CONTINUE = 4'h2;
   localparam logic [3:0] SX_STAT_END      = 4'h3;
   localparam logic [3:0] SX_TYPE_DATA64   = 4'h3;

   localparam logic [3:0] SX_COUNT_MASK  = 4'h0F;
   localparam logic [2:0] SX_MAX_PAYLOAD = 3'd6;
   localparam logic [2:0] SX_MIN_WORDS   = 3'd2;

   // result kinds
   localparam logic [1:0] KIND_OPEN    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_CLOSE   = 2'd2;
   localparam logic [1:0] KIND_MARKER  = 2'd3;

   typedef struct packed {
      logic       load_pkt;
      logic       load_out;
      logic [1:0] kind;
      logic [2:0] idx;
      logic       discard;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic       handled;
      logic       opens;
      logic       closes;
      logic [2:0] count;
      logic       out_free;
   } stat_type;

endpackage
`default_nettype wire

/* sv/umpsx_dpath.sv */
`default_nettype none
module umpsx_dpath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  is_message,
   input  wire [2:0]            word_count,
   input  wire [31:0]           word_first,
   input  wire [31:0]           word_second,
   input  umpsx_pkg::cmd_type   cmd,
   output umpsx_pkg::stat_type  stat,
   output logic [7:0]           rsp_data_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_line_end,
   output logic                 rsp_discard_line,
   output logic                 rsp_last,
   output logic                 rsp_valid,
   input  wire                  rsp_ready
);
   import umpsx_pkg::*;

   logic [47:0] payload_ff, payload_in;
   logic [7:0]  byte_ff, byte_in;
   logic        bvalid_ff, bvalid_in;
   logic        lend_ff, lend_in;
   logic        discard_ff, discard_in;
   logic        last_ff, last_in;
   logic        valid_ff, valid_in;

   logic [3:0]  status;
   logic [3:0]  count_raw;
   logic [7:0]  sel_byte;

   // decode of the incoming packet
   always_comb begin
      status    = word_first[23:20];
      count_raw = word_first[19:16] & SX_COUNT_MASK;
      stat.handled = is_message && (word_count >= SX_MIN_WORDS)
                     && (word_first[31:28] == SX_TYPE_DATA64);
      stat.opens  = (status == SX_STAT_COMPLETE) || (status == SX_STAT_START);
      stat.closes = (status == SX_STAT_COMPLETE) || (status == SX_STAT_END);
      if (count_raw > {1'b0, SX_MAX_PAYLOAD}) begin
         stat.count = SX_MAX_PAYLOAD;
      end else begin
         stat.count = count_raw[2:0];
      end
      stat.out_free = !valid_ff || rsp_ready;
   end

   // payload byte 0 in the top bits, in wire order
   always_comb begin
      case (cmd.idx)
         3'd0:    sel_byte = payload_ff[47:40];
         3'd1:    sel_byte = payload_ff[39:32];
         3'd2:    sel_byte = payload_ff[31:24];
         3'd3:    sel_byte = payload_ff[23:16];
         3'd4:    sel_byte = payload_ff[15:8];
         3'd5:    sel_byte = payload_ff[7:0];
         default: sel_byte = 8'h00;
      endcase
   end

   always_comb begin
      payload_in = cmd.load_pkt ? {word_first[15:0], word_second} : payload_ff;
      byte_in    = byte_ff;
      bvalid_in  = bvalid_ff;
      lend_in    = lend_ff;
      discard_in = discard_ff;
      last_in    = last_ff;
      valid_in   = valid_ff && !rsp_ready;
      if (cmd.load_out) begin
         valid_in   = 1'b1;
         discard_in = cmd.discard;
         last_in    = cmd.last;
         bvalid_in  = 1'b1;
         lend_in    = 1'b0;
         case (cmd.kind)
            KIND_OPEN:    byte_in = SX_START_BYTE;
            KIND_PAYLOAD: byte_in = sel_byte;
            KIND_CLOSE: begin
               byte_in = SX_END_BYTE;
               lend_in = 1'b1;
            end
            KIND_MARKER: begin
               byte_in   = 8'h00;
               bvalid_in = 1'b0;
               lend_in   = 1'b1;
            end
            default:      byte_in = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      byte_ff    <= byte_in;
      bvalid_ff  <= bvalid_in;
      lend_ff    <= lend_in;
      discard_ff <= discard_in;
      last_ff    <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_data_byte    = byte_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_line_end     = lend_ff;
   assign rsp_discard_line = discard_ff;
   assign rsp_last         = last_ff;
   assign rsp_valid        = valid_ff;

endmodule
`default_nettype wire

/* sv/umpsx_ctrl.sv */
`default_nettype none
module umpsx_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  action,
   output logic                 req_ready,
   input  umpsx_pkg::stat_type  stat,
   output umpsx_pkg::cmd_type   cmd
);
   import umpsx_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic       state_ff, state_in;
   logic [2:0] pos_ff, pos_in;
   logic [3:0] total_ff, total_in;
   logic       open_ff, open_in;
   logic       close_ff, close_in;
   logic       marker_ff, marker_in;
   logic       discard_ff, discard_in;
   logic       intx_ff, intx_in;

   logic       accept;
   logic       active;
   logic [3:0] n_new;
   logic       at_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign active    = stat.opens || intx_ff;
   assign at_last   = ({1'b0, pos_ff} == (total_ff - 4'd1));

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      total_in   = total_ff;
      open_in    = open_ff;
      close_in   = close_ff;
      marker_in  = marker_ff;
      discard_in = discard_ff;
      intx_in    = intx_ff;
      n_new      = 4'd0;

      cmd.load_pkt = accept;
      cmd.load_out = 1'b0;
      cmd.last     = at_last;
      cmd.discard  = discard_ff && (pos_ff == 3'd0);
      cmd.idx      = pos_ff - {2'b00, open_ff};
      if (marker_ff) begin
         cmd.kind = KIND_MARKER;
      end else if (open_ff && (pos_ff == 3'd0)) begin
         cmd.kind = KIND_OPEN;
      end else if (close_ff && at_last) begin
         cmd.kind = KIND_CLOSE;
      end else begin
         cmd.kind = KIND_PAYLOAD;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in     = 3'd0;
               marker_in  = 1'b0;
               open_in    = 1'b0;
               close_in   = 1'b0;
               discard_in = 1'b0;
               if (action) begin
                  if (intx_ff) begin
                     n_new     = 4'd1;
                     marker_in = 1'b1;
                     intx_in   = 1'b0;
                  end
               end else if (stat.handled && active) begin
                  open_in    = stat.opens;
                  close_in   = stat.closes;
                  discard_in = stat.opens && intx_ff;
                  intx_in    = !stat.closes;
                  n_new      = {3'b000, stat.opens} + {1'b0, stat.count}
                               + {3'b000, stat.closes};
               end
               total_in = n_new;
               if (n_new != 4'd0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               pos_in       = pos_ff + 3'd1;
               if (at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      total_ff   <= total_in;
      open_ff    <= open_in;
      close_ff   <= close_in;
      marker_ff  <= marker_in;
      discard_ff <= discard_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         intx_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         intx_ff  <= intx_in;
      end
   end

endmodule
`default_nettype wire

/* sv/ump_sysex7_to_byte_stream_unit.sv */
// UMP SysEx7 packets to a MIDI 1.0 system-exclusive byte stream.
// req channel: one transfer per 64-bit packet or end-of-selection mark.
//   tuser[0] = action (1 = end of selection), tuser[1] = is_message.
//   tdata holds word_count, word_first and word_second from bit 0 up.
// rsp channel: one transfer per emitted byte or bare line-end marker.
//   tdata = data_byte, tuser = byte_valid, line_end, discard_line,
//   tlast marks the final result caused by one request.
// After the request transfer, the sequencer's emit state loads the first
// result into the output register; then one result per cycle follows
// while rsp_tready allows. A packet giving n results (up to 8: F0, six
// payload bytes, F7) holds req_tready low until its last result is loaded.
// The rate is set by the single output register that each result passes through.
// A request giving no result keeps the sequencer idle, so such items stream freely.
// The next request is taken while the final result still waits on rsp.
// A stalled receiver (rsp_tready low) holds the output register and
// freezes the sequencer; nothing is lost or repeated.
// Reset (synchronous) closes any open transmission and empties the output.
`default_nettype none
module ump_sysex7_to_byte_stream_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [71:0]  req_tdata,   // word_count[2:0], word_first[34:3], word_second[66:35]
   input  wire [1:0]   req_tuser,   // action[0], is_message[1]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // data_byte[7:0]
   output logic [2:0]  rsp_tuser,   // byte_valid[0], line_end[1], discard_line[2]
   output logic        rsp_tlast    // last result of this request
);
   import umpsx_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: owns the open-line flag and the per-request result plan
   umpsx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .action    (req_tuser[0]),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // packet decode, payload hold and output register
   umpsx_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .is_message       (req_tuser[1]),
      .word_count       (req_tdata[2:0]),
      .word_first       (req_tdata[34:3]),
      .word_second      (req_tdata[66:35]),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_data_byte    (rsp_tdata),
      .rsp_byte_valid   (rsp_tuser[0]),
      .rsp_line_end     (rsp_tuser[1]),
      .rsp_discard_line (rsp_tuser[2]),
      .rsp_last         (rsp_tlast),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready)
   );

endmodule
`default_nettype wire
